// ===== rtl/kmer_seed_extractor_top_assert.svh =====
// Assertion macros for the seed extractor.
// Each macro checks a property on the rising edge of i_clk and is disabled during reset.
// Defining ASSERT_OFF turns every macro into an empty statement.
`ifndef KMER_SEED_EXTRACTOR_TOP_ASSERT_SVH
`define KMER_SEED_EXTRACTOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent holds in the same cycle as the antecedent.
`define KSE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kse same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define KSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kse next-cycle check failed");

`else

`define KSE_ASSERT_SAME(lbl, ante, cons)
`define KSE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/kse_pkg.sv =====
package kse_pkg;

    // One input item: a single nucleotide.
    typedef struct packed {
        logic [1:0]  base_code;
        logic        is_masked;
        logic        chromosome_first;
        logic [31:0] global_position;
    } t_in_item;

    // One result item: a sampled seed.
    typedef struct packed {
        logic [31:0] seed_key;
        logic [31:0] seed_start;
    } t_out_item;

    // A seed that passed the bucket filter and still needs the stride check.
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] start;
    } t_cand;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

    // Configuration values shared by the front and back parts.
    typedef struct packed {
        logic [15:0] sample_stride;
        logic [3:0]  bucket_width;
        logic [11:0] bucket_select;
    } t_cfg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SAMPLE_STRIDE = 2'd0;
    localparam logic [1:0] CFG_BUCKET_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_BUCKET_SELECT = 2'd2;

    localparam int unsigned KEY_W      = 32;
    localparam int unsigned RUN_W      = 5;
    localparam int unsigned STRIDE_W   = 16;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = 2;
    localparam int unsigned FIFO_CNT_W = 3;

endpackage

// ===== rtl/kmer_seed_extractor_top.sv =====
// Rolling 2-bit k-mer seed extractor. Each accepted nucleotide shifts into a
// 32-bit key; masked bases and chromosome starts clear the key and the run.
// Bases that complete a seed and pass the bucket filter are queued (four
// entries) for the stride check, a bit-serial remainder unit that loads each
// queued seed and then runs 32 remainder steps. Bases that yield no candidate
// are not queued, and the input stalls only while the queue is full.
// Results leave through an output register.
// Configuration: index 0 sample_stride, 1 bucket_width, 2 bucket_select;
// write only while idle, index 3 is ignored.
`include "kmer_seed_extractor_top_assert.svh"

module kmer_seed_extractor_top #(
    parameter int unsigned SEED_LENGTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  kse_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kse_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import kse_pkg::*;

    t_cfg       r_cfg;
    t_fifo_stat w_fifo_stat;
    t_cand      w_push_data;
    t_cand      w_head;
    logic       w_push;
    logic       w_pop;
    logic       w_busy;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_stride <= 16'd1;
            r_cfg.bucket_width  <= '0;
            r_cfg.bucket_select <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SAMPLE_STRIDE: r_cfg.sample_stride <= i_cfg_data;
                CFG_BUCKET_WIDTH:  r_cfg.bucket_width  <= i_cfg_data[3:0];
                CFG_BUCKET_SELECT: r_cfg.bucket_select <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    kse_front #(
        .SEED_LENGTH (SEED_LENGTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_cfg       (r_cfg),
        .i_fifo_stat (w_fifo_stat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    kse_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_stat      (w_fifo_stat)
    );

    kse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_fifo_stat (w_fifo_stat),
        .o_pop       (w_pop),
        .i_cfg       (r_cfg),
        .o_busy      (w_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // Queue never overflows or underflows
    `KSE_ASSERT_SAME(a_no_push_full, w_push, !w_fifo_stat.full)
    `KSE_ASSERT_SAME(a_no_pop_empty, w_pop, !w_fifo_stat.empty)
    // With nothing queued or in progress, no result can appear
    `KSE_ASSERT_NEXT(a_no_phantom, !o_out_valid && w_fifo_stat.empty && !w_busy, !o_out_valid)

endmodule

// ===== rtl/kse_fifo.sv =====
module kse_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  kse_pkg::t_cand    i_push_data,
    input  logic              i_pop,
    output kse_pkg::t_cand    o_head,
    output kse_pkg::t_fifo_stat o_stat
);
    import kse_pkg::*;

    t_cand                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    // Storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));

endmodule

// ===== rtl/kse_front.sv =====
module kse_front #(
    parameter int unsigned SEED_LENGTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  kse_pkg::t_in_item   i_in_item,
    input  kse_pkg::t_cfg       i_cfg,
    input  kse_pkg::t_fifo_stat i_fifo_stat,
    output logic                o_push,
    output kse_pkg::t_cand      o_push_data
);
    import kse_pkg::*;

    localparam logic [RUN_W-1:0] SeedLen    = RUN_W'(SEED_LENGTH);
    localparam logic [31:0]      StartOffs  = 32'(SEED_LENGTH - 1);

    logic [KEY_W-1:0] r_key;
    logic [RUN_W-1:0] r_run;
    logic [KEY_W-1:0] n_key;
    logic [RUN_W-1:0] n_run;

    logic             w_accept;
    logic [KEY_W-1:0] w_base_key;
    logic [RUN_W-1:0] w_base_run;
    logic [KEY_W-1:0] w_shift_key;
    logic [RUN_W-1:0] w_inc_run;
    logic [14:0]      w_top_bits;
    logic             w_bucket_ok;
    logic             w_seed;

    // Only a full queue holds the input side back
    assign o_in_stall = i_fifo_stat.full;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Rolling key and run update
    always_comb begin
        w_base_key  = i_in_item.chromosome_first ? '0 : r_key;
        w_base_run  = i_in_item.chromosome_first ? '0 : r_run;
        w_shift_key = {w_base_key[KEY_W-3:0], i_in_item.base_code};
        w_inc_run   = (w_base_run < SeedLen) ? w_base_run + 1'b1 : w_base_run;
        if (i_in_item.is_masked) begin
            n_key = '0;
            n_run = '0;
        end else begin
            n_key = w_shift_key;
            n_run = w_inc_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_run <= '0;
        end else if (w_accept) begin
            r_key <= n_key;
            r_run <= n_run;
        end
    end

    // Bucket filter on the top bucket_width key bits
    always_comb begin
        w_top_bits  = w_shift_key[KEY_W-1:KEY_W-15] >> (4'd15 - i_cfg.bucket_width);
        w_bucket_ok = (i_cfg.bucket_width == '0) ||
                      (w_top_bits == {3'b000, i_cfg.bucket_select});
    end

    // A full-length seed that passes the filter goes on to the stride check
    assign w_seed = !i_in_item.is_masked && (w_inc_run >= SeedLen);
    assign o_push = w_accept && w_seed && w_bucket_ok;
    assign o_push_data.key   = w_shift_key;
    assign o_push_data.start = i_in_item.global_position - StartOffs;

endmodule

// ===== rtl/kse_back.sv =====
module kse_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kse_pkg::t_cand      i_head,
    input  kse_pkg::t_fifo_stat i_fifo_stat,
    output logic                o_pop,
    input  kse_pkg::t_cfg       i_cfg,
    output logic                o_busy,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output kse_pkg::t_out_item  o_out_item
);
    import kse_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [4:0]          r_cnt;
    logic [STRIDE_W-1:0] r_rem;
    logic [KEY_W-1:0]    r_dvd;
    t_cand               r_cand;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [STRIDE_W-1:0] w_div;
    logic [STRIDE_W:0]   w_trial;
    logic [STRIDE_W:0]   w_diff;
    logic [STRIDE_W-1:0] w_rem_next;
    logic                w_out_free;
    logic                w_load_out;

    // One restoring remainder step per cycle, dividend MSB first
    always_comb begin
        w_div      = (i_cfg.sample_stride == '0) ? STRIDE_W'(1) : i_cfg.sample_stride;
        w_trial    = {r_rem, r_dvd[KEY_W-1]};
        w_diff     = w_trial - {1'b0, w_div};
        w_rem_next = (w_trial >= {1'b0, w_div}) ? w_diff[STRIDE_W-1:0]
                                                  : w_trial[STRIDE_W-1:0];
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Sequencer
    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_fifo_stat.empty) begin
                    o_pop   = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == 5'd31) begin
                    if (w_rem_next != '0) begin
                        n_state = S_IDLE;
                    end else if (w_out_free) begin
                        w_load_out = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cand <= i_head;
            r_dvd  <= i_head.start;
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (r_state == S_DIV) begin
            r_dvd <= {r_dvd[KEY_W-2:0], 1'b0};
            r_rem <= w_rem_next;
            r_cnt <= r_cnt + 1'b1;
        end
        if (w_load_out) begin
            r_out.seed_key   <= r_cand.key;
            r_out.seed_start <= r_cand.start;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
